### hw/rtl/pata_pkg.sv
package pata_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam int TIME_W   = 32;
   localparam int ID_W     = 16;
   localparam int AMOUNT_W = 32;
   localparam int TOTAL_W  = 40;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIME_W-1:0] REMEMBER_RESET = 32'd60000;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_FIND     = 1'b1;

   localparam logic REG_REMEMBER_TIME = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FIND_HIT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FIND_MISS = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]    source;
      logic [ID_W-1:0]    target;
      logic [TOTAL_W-1:0] total;
      logic [TIME_W-1:0]  last_time;
   } entry_type;

   typedef struct packed {
      logic mark;
      logic shift;
      logic update;
      logic insert;
      logic find;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_COMPACT,
      ST_LOOKUP
   } state_type;

endpackage

### hw/rtl/pata_req_if.sv
interface pata_req_if import pata_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [TIME_W-1:0]   now_time;
   logic [ID_W-1:0]     source_id;
   logic [ID_W-1:0]     target_id;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, kind, now_time, source_id, target_id, amount,
                   input ready);
   modport sink (input valid, kind, now_time, source_id, target_id, amount,
                 output ready);
endinterface

### hw/rtl/pata_rsp_if.sv
interface pata_rsp_if import pata_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     out_target_id;
   logic [TOTAL_W-1:0]  out_total;
   logic [TIME_W-1:0]   out_last_time;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, out_target_id, out_total, out_last_time,
                   entry_count, input ready);
   modport sink (input valid, status, out_target_id, out_total, out_last_time,
                 entry_count, output ready);
endinterface

### hw/rtl/pata_cell.sv
module pata_cell import pata_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [TIME_W-1:0] now_time,
   input  logic [TIME_W-1:0] remember_time,
   input  logic [ID_W-1:0]   key_source,
   input  logic [ID_W-1:0]   key_target,
   input  logic [TOTAL_W-1:0] upd_total,
   input  entry_type         new_entry,
   input  logic              next_valid,
   input  entry_type         next_entry,
   output logic              own_valid,
   output entry_type         own_entry,
   input  logic              free_in,
   output logic              free_out,
   input  logic [CW-1:0]     idx_in,
   output logic [CW-1:0]     idx_out,
   input  logic              hit_in,
   output logic              hit_out,
   input  entry_type         sel_in,
   output entry_type         sel_out,
   output logic              need_shift
);

   logic              valid_ff;
   logic              valid_in;
   entry_type         entry_ff;
   entry_type         entry_in;
   logic              match;
   logic              expired;
   logic [TIME_W-1:0] age;

   always_comb begin
      age        = now_time - entry_ff.last_time;
      expired    = age > remember_time;
      match      = valid_ff && (entry_ff.source == key_source) &&
                   (ctrl.find || (entry_ff.target == key_target));
      free_out   = free_in | ~valid_ff;
      idx_out    = free_in ? idx_in : (valid_ff ? CW'(INDEX + 1) : CW'(INDEX));
      hit_out    = hit_in | match;
      sel_out    = (match && !hit_in) ? entry_ff : sel_in;
      need_shift = valid_ff & free_in;
      own_valid  = valid_ff;
      own_entry  = entry_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.mark) begin
         valid_in = valid_ff & ~expired;
      end else if (ctrl.shift && free_out) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (ctrl.update && match && !hit_in) begin
         entry_in.total     = upd_total;
         entry_in.last_time = now_time;
      end else if (ctrl.insert && !valid_ff && !free_in) begin
         valid_in = 1'b1;
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hw/rtl/pair_accumulate_table_with_aging.sv
// Ordered table of source and target pairs with running totals and idle aging.
// Items arrive on req_chan as valid/ready beats: a register beat ages the
// table, then updates the matching pair, appends it, or drops it when the
// table is full; a find beat returns the oldest entry whose source matches.
// Each beat gives one result beat on rsp_chan. The remember time is written
// through the APB-style csr port. The table is a row of cells, one entry per
// cell. A find beat goes straight to the lookup step. A register beat passes
// the mark step, which drops expired entries, then the compact step, which
// shifts every entry above the lowest gap down by one cell per step until no
// gap is left below a valid entry (at most as many steps as entries were
// removed), then the lookup step. When the receiver stalls, the result waits
// in the output register and the next item may still be accepted and aged,
// but it holds in the lookup step until the output register is free. A new
// item is accepted only once the last one has left the lookup step. Reset
// empties the table, sets the remember time to 60000, drops any pending result.
module pair_accumulate_table_with_aging import pata_pkg::*; #(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   pata_req_if.sink              req_chan,
   pata_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff;
   state_type state_in;

   logic [TIME_W-1:0]   remember_ff;
   logic                kind_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [ID_W-1:0]     src_ff;
   logic [ID_W-1:0]     tgt_ff;
   logic [AMOUNT_W-1:0] amount_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     tgt_out_ff;
   logic [TOTAL_W-1:0]  total_out_ff;
   logic [TIME_W-1:0]   time_out_ff;
   logic [COUNT_W-1:0]  count_out_ff;

   cell_ctrl_type ctrl;
   logic          req_accept;
   logic          out_free;
   logic          commit;
   logic          need_any;

   logic          valid_w [ENTRIES+1];
   entry_type     entry_w [ENTRIES+1];
   logic          free_w  [ENTRIES+1];
   logic [CW-1:0] idx_w   [ENTRIES+1];
   logic          hit_w   [ENTRIES+1];
   entry_type     sel_w   [ENTRIES+1];
   logic [ENTRIES-1:0] need_v;

   logic               any_hit;
   logic               has_free;
   entry_type          sel;
   logic [TOTAL_W-1:0] amount_ext;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] upd_total;
   entry_type          new_entry;
   logic [CW-1:0]      count_next;

   logic [STATUS_W-1:0] status_in;
   logic [ID_W-1:0]     tgt_out_in;
   logic [TOTAL_W-1:0]  total_out_in;
   logic [TIME_W-1:0]   time_out_in;

   assign valid_w[ENTRIES] = 1'b0;
   assign entry_w[ENTRIES] = '0;
   assign free_w[0]        = 1'b0;
   assign idx_w[0]         = CW'(ENTRIES);
   assign hit_w[0]         = 1'b0;
   assign sel_w[0]         = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pata_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .now_time      (now_ff),
         .remember_time (remember_ff),
         .key_source    (src_ff),
         .key_target    (tgt_ff),
         .upd_total     (upd_total),
         .new_entry     (new_entry),
         .next_valid    (valid_w[i+1]),
         .next_entry    (entry_w[i+1]),
         .own_valid     (valid_w[i]),
         .own_entry     (entry_w[i]),
         .free_in       (free_w[i]),
         .free_out      (free_w[i+1]),
         .idx_in        (idx_w[i]),
         .idx_out       (idx_w[i+1]),
         .hit_in        (hit_w[i]),
         .hit_out       (hit_w[i+1]),
         .sel_in        (sel_w[i]),
         .sel_out       (sel_w[i+1]),
         .need_shift    (need_v[i])
      );
   end

   always_comb begin
      need_any   = |need_v;
      any_hit    = hit_w[ENTRIES];
      has_free   = free_w[ENTRIES];
      sel        = sel_w[ENTRIES];
      amount_ext = {{(TOTAL_W-AMOUNT_W){amount_ff[AMOUNT_W-1]}}, amount_ff};
      sum        = {sel.total[TOTAL_W-1], sel.total} + {amount_ext[TOTAL_W-1], amount_ext};
      if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
         upd_total = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         upd_total = sum[TOTAL_W-1:0];
      end
      new_entry.source    = src_ff;
      new_entry.target    = tgt_ff;
      new_entry.total     = amount_ext;
      new_entry.last_time = now_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.kind == KIND_FIND) ? ST_LOOKUP : ST_MARK;
            end
         end
         ST_MARK: begin
            state_in = ST_COMPACT;
         end
         ST_COMPACT: begin
            if (!need_any) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      req_accept     = req_chan.valid && req_chan.ready;
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      commit         = (state_ff == ST_LOOKUP) && out_free;
      ctrl.mark      = (state_ff == ST_MARK);
      ctrl.shift     = (state_ff == ST_COMPACT) && need_any;
      ctrl.find      = (kind_ff == KIND_FIND);
      ctrl.update    = commit && (kind_ff == KIND_REGISTER) && any_hit;
      ctrl.insert    = commit && (kind_ff == KIND_REGISTER) && !any_hit && has_free;
      count_next     = idx_w[ENTRIES] + CW'(ctrl.insert);
   end

   always_comb begin
      status_in    = STATUS_DROPPED;
      tgt_out_in   = '0;
      total_out_in = '0;
      time_out_in  = '0;
      if (kind_ff == KIND_FIND) begin
         if (any_hit) begin
            status_in    = STATUS_FIND_HIT;
            tgt_out_in   = sel.target;
            total_out_in = sel.total;
            time_out_in  = sel.last_time;
         end else begin
            status_in = STATUS_FIND_MISS;
         end
      end else if (any_hit) begin
         status_in    = STATUS_UPDATED;
         tgt_out_in   = sel.target;
         total_out_in = upd_total;
         time_out_in  = now_ff;
      end else if (has_free) begin
         status_in    = STATUS_INSERTED;
         tgt_out_in   = tgt_ff;
         total_out_in = amount_ext;
         time_out_in  = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         remember_ff  <= REMEMBER_RESET;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr[2] == REG_REMEMBER_TIME)) begin
            remember_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff   <= req_chan.kind;
         now_ff    <= req_chan.now_time;
         src_ff    <= req_chan.source_id;
         tgt_ff    <= req_chan.target_id;
         amount_ff <= req_chan.amount;
      end
      if (commit) begin
         status_ff    <= status_in;
         tgt_out_ff   <= tgt_out_in;
         total_out_ff <= total_out_in;
         time_out_ff  <= time_out_in;
         count_out_ff <= COUNT_W'(count_next);
      end
   end

   always_comb begin
      rsp_chan.valid         = rsp_valid_ff;
      rsp_chan.status        = status_ff;
      rsp_chan.out_target_id = tgt_out_ff;
      rsp_chan.out_total     = total_out_ff;
      rsp_chan.out_last_time = time_out_ff;
      rsp_chan.entry_count   = count_out_ff;
      csr_pready             = 1'b1;
      csr_prdata             = (csr_paddr[2] == REG_REMEMBER_TIME) ? remember_ff : '0;
   end

endmodule
